[sv/round_robin_task_scheduler_unit_macros.svh]
// ----------------------------------------------------------------------------
// rrts assertion macros
// concurrent assertion helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RRTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RRTS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RRTS_ASSERT(label, clk, rst, prop, msg)
`define RRTS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[sv/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// rrts package
// shared types and constants of the task scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rrts_pkg;
   localparam int MaxTasksDefault = 8;
   localparam int QueueDepth      = 2;

   typedef enum logic [2:0] {
      MODE_CREATE  = 3'd0,
      MODE_TICK    = 3'd1,
      MODE_YIELD   = 3'd2,
      MODE_SLEEP   = 3'd3,
      MODE_SUSPEND = 3'd4,
      MODE_WAKEUP  = 3'd5,
      MODE_SET_SEC = 3'd6,
      MODE_SET_MS  = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NO_TASK  = 2'd2,
      ST_NOT_ALLOC = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_FREE = 2'd0, PH_READY = 2'd1, PH_SLEEP = 2'd2, PH_SUSP = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      EX_IDLE, EX_DIV, EX_RDROP, EX_SDROP, EX_TICK, EX_RESCHED, EX_DONE
   } exec_state_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  task_id;
      logic [15:0] sleep_ms;
      logic [31:0] time_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        current_valid;
      logic [2:0]  current_task;
      logic [2:0]  created_task;
      logic [3:0]  woken_count;
      logic [31:0] seconds_now;
      logic [31:0] millis_now;
   } rsp_type;

   // decoded command carried from front to back
   typedef struct packed {
      req_type req;
      logic    needs_div;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic stall;
   } hs_type;
endpackage

[sv/rrts_front.sv]
// ----------------------------------------------------------------------------
// rrts front
// accepts request beats, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "round_robin_task_scheduler_unit_macros.svh"
module rrts_front
   import rrts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output hs_type  cmd_hs,
   input  logic    cmd_pop,
   output cmd_type cmd_data
);
   localparam int PtrW = $clog2(QueueDepth);

   cmd_type           q_ff [QueueDepth];
   logic [PtrW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]     cnt_ff, cnt_in;
   logic              push;
   cmd_type           cmd;

   assign req_stall = (cnt_ff == (PtrW+1)'(QueueDepth));
   assign push      = req_valid && !req_stall;

   // sleep needs the quotient, tick and set seconds need the countdown reload
   always_comb begin
      cmd.req       = req_data;
      cmd.needs_div = req_data.mode inside {MODE_SLEEP, MODE_TICK, MODE_SET_SEC};
   end

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = cmd_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= cmd;
   end

   assign cmd_hs.valid = (cnt_ff != '0);
   assign cmd_hs.stall = !cmd_pop;
   assign cmd_data     = q_ff[rd_ff];

   `RRTS_ASSERT(a_pop_nonempty, clock, reset, cmd_pop |-> cnt_ff != '0, "pop of empty queue")
   `RRTS_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= (PtrW+1)'(QueueDepth), "queue overflow")
   `RRTS_ASSERT(a_cnt_track, clock, reset, (push && !cmd_pop) |=> cnt_ff == $past(cnt_ff) + 1'b1, "queue count slip")
endmodule

[sv/rrts_back.sv]
// ----------------------------------------------------------------------------
// rrts back
// task table, ready and sleep lists, time counters; one command at a time
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "round_robin_task_scheduler_unit_macros.svh"
module rrts_back
   import rrts_pkg::*;
#(
   parameter int MAX_TASKS = MaxTasksDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  hs_type  cmd_hs,
   output logic    cmd_pop,
   input  cmd_type cmd_data,
   input  logic [7:0] tick_rate,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam logic [15:0] MsPerSecond = 16'd1000;

   exec_state_type st_ff, st_in;
   cmd_type     cur_ff;
   phase_type   phase_ff [MAX_TASKS];
   logic [15:0] delay_ff [MAX_TASKS];
   logic [SW-1:0] rlist_ff [MAX_TASKS];
   logic [SW-1:0] slist_ff [MAX_TASKS];
   logic [CW-1:0] rcnt_ff, scnt_ff, alloc_ff;
   logic [CW-1:0] idx_ff, keep_ff, woke_ff;
   logic        run_v_ff;
   logic [SW-1:0] run_ff, tgt_ff;
   logic [9:0]  cd_ff;
   logic [31:0] sec_ff, ms_ff;
   logic [1:0]  status_ff;
   logic [2:0]  created_ff;
   // restoring divider, one quotient bit per cycle
   logic [15:0] dq_ff, dr_ff;
   logic [4:0]  dn_ff;
   logic [16:0] dtrial;
   logic [7:0]  divisor;
   logic        out_v_ff, out_v_in;
   rsp_type     out_ff;
   logic        out_free;
   logic [SW-1:0] sl_slot;
   logic [15:0] sl_dec;

   assign divisor  = (tick_rate == 8'd0) ? 8'd1 : tick_rate;
   assign dtrial   = {dr_ff, dq_ff[15]} - {9'd0, divisor};
   assign out_free = !out_v_ff || !rsp_stall;
   assign out_v_in = (st_ff == EX_DONE && out_free) ? 1'b1 : (rsp_stall ? out_v_ff : 1'b0);
   assign sl_slot  = slist_ff[idx_ff[SW-1:0]];
   assign sl_dec   = (delay_ff[sl_slot] != 16'd0) ? delay_ff[sl_slot] - 16'd1 : 16'd0;

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         EX_IDLE: if (cmd_hs.valid) st_in = EX_DIV;
         EX_DIV: begin
            if (!cur_ff.needs_div || dn_ff == 5'd16) begin
               case (cur_ff.req.mode)
                  MODE_SLEEP, MODE_SUSPEND: st_in = run_v_ff ? EX_RDROP : EX_DONE;
                  MODE_WAKEUP: begin
                     st_in = (CW'(cur_ff.req.task_id) >= alloc_ff ||
                              32'(cur_ff.req.task_id) >= 32'(MAX_TASKS)) ? EX_DONE : EX_RDROP;
                  end
                  MODE_CREATE: st_in = (alloc_ff >= CW'(MAX_TASKS)) ? EX_DONE : EX_RDROP;
                  MODE_TICK:   st_in = EX_TICK;
                  MODE_YIELD:  st_in = EX_RESCHED;
                  default:     st_in = EX_DONE;
               endcase
            end
         end
         EX_RDROP: if (idx_ff == rcnt_ff) st_in = EX_SDROP;
         EX_SDROP: if (idx_ff == scnt_ff) begin
            st_in = (cur_ff.req.mode == MODE_SLEEP || cur_ff.req.mode == MODE_SUSPEND)
                    ? EX_RESCHED : EX_DONE;
         end
         EX_TICK: if (idx_ff == scnt_ff) st_in = EX_RESCHED;
         EX_RESCHED: st_in = EX_DONE;
         EX_DONE: if (out_free) st_in = EX_IDLE;
         default: st_in = EX_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop = (st_ff == EX_IDLE) && cmd_hs.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= EX_IDLE;
         out_v_ff <= 1'b0;
         rcnt_ff  <= '0;
         scnt_ff  <= '0;
         alloc_ff <= '0;
         run_v_ff <= 1'b0;
         run_ff   <= '0;
         cd_ff    <= 10'd1000;
         sec_ff   <= '0;
         ms_ff    <= '0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            phase_ff[i] <= PH_FREE;
            delay_ff[i] <= '0;
         end
      end else begin
         st_ff    <= st_in;
         out_v_ff <= out_v_in;
         case (st_ff)
            EX_IDLE: begin
               cur_ff    <= cmd_data;
               idx_ff    <= '0;
               keep_ff   <= '0;
               woke_ff   <= '0;
               status_ff <= ST_OK;
               created_ff <= '0;
               // sleep divides its duration, the others divide one second
               dq_ff     <= (cmd_data.req.mode == MODE_SLEEP) ? cmd_data.req.sleep_ms
                                                              : MsPerSecond;
               dr_ff     <= '0;
               dn_ff     <= '0;
            end
            EX_DIV: begin
               if (cur_ff.needs_div && dn_ff != 5'd16) begin
                  dn_ff <= dn_ff + 5'd1;
                  if (!dtrial[16]) begin
                     dr_ff <= dtrial[15:0];
                     dq_ff <= {dq_ff[14:0], 1'b1};
                  end else begin
                     dr_ff <= {dr_ff[14:0], dq_ff[15]};
                     dq_ff <= {dq_ff[14:0], 1'b0};
                  end
               end else begin
                  idx_ff  <= '0;
                  keep_ff <= '0;
                  case (cur_ff.req.mode)
                     MODE_CREATE: begin
                        if (alloc_ff >= CW'(MAX_TASKS)) status_ff <= ST_FULL;
                        else begin
                           tgt_ff     <= alloc_ff[SW-1:0];
                           created_ff <= 3'(alloc_ff);
                           delay_ff[alloc_ff[SW-1:0]] <= '0;
                           alloc_ff   <= alloc_ff + 1'b1;
                        end
                     end
                     MODE_SLEEP, MODE_SUSPEND: begin
                        if (!run_v_ff) status_ff <= ST_NO_TASK;
                        tgt_ff <= run_ff;
                     end
                     MODE_WAKEUP: begin
                        if (CW'(cur_ff.req.task_id) >= alloc_ff ||
                            32'(cur_ff.req.task_id) >= 32'(MAX_TASKS))
                           status_ff <= ST_NOT_ALLOC;
                        tgt_ff <= SW'(cur_ff.req.task_id);
                     end
                     MODE_TICK: begin
                        if (cd_ff == 10'd1) begin
                           sec_ff <= sec_ff + 32'd1;
                           cd_ff  <= dq_ff[9:0];
                        end else cd_ff <= cd_ff - 10'd1;
                        ms_ff <= ms_ff + 32'(tick_rate);
                     end
                     MODE_SET_SEC: begin
                        sec_ff <= cur_ff.req.time_value;
                        cd_ff  <= dq_ff[9:0];
                     end
                     MODE_SET_MS: ms_ff <= cur_ff.req.time_value;
                     default: ;
                  endcase
               end
            end
            // compact ready list without the target slot
            EX_RDROP: begin
               if (idx_ff == rcnt_ff) begin
                  rcnt_ff <= keep_ff;
                  idx_ff  <= '0;
                  keep_ff <= '0;
               end else begin
                  if (rlist_ff[idx_ff[SW-1:0]] != tgt_ff) begin
                     rlist_ff[keep_ff[SW-1:0]] <= rlist_ff[idx_ff[SW-1:0]];
                     keep_ff <= keep_ff + 1'b1;
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            // compact sleep list, then place the target
            EX_SDROP: begin
               if (idx_ff == scnt_ff) begin
                  if (cur_ff.req.mode == MODE_SLEEP) begin
                     delay_ff[tgt_ff] <= dq_ff;
                     phase_ff[tgt_ff] <= PH_SLEEP;
                     if (keep_ff < CW'(MAX_TASKS)) begin
                        slist_ff[keep_ff[SW-1:0]] <= tgt_ff;
                        scnt_ff <= keep_ff + 1'b1;
                     end else scnt_ff <= keep_ff;
                  end else begin
                     scnt_ff <= keep_ff;
                     if (cur_ff.req.mode == MODE_SUSPEND) phase_ff[tgt_ff] <= PH_SUSP;
                     else begin
                        phase_ff[tgt_ff] <= PH_READY;
                        if (rcnt_ff < CW'(MAX_TASKS)) begin
                           rlist_ff[rcnt_ff[SW-1:0]] <= tgt_ff;
                           rcnt_ff <= rcnt_ff + 1'b1;
                        end
                     end
                  end
               end else begin
                  if (slist_ff[idx_ff[SW-1:0]] != tgt_ff) begin
                     slist_ff[keep_ff[SW-1:0]] <= slist_ff[idx_ff[SW-1:0]];
                     keep_ff <= keep_ff + 1'b1;
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            // one sleeper per cycle; kept entries compact in place
            EX_TICK: begin
               if (idx_ff == scnt_ff) scnt_ff <= keep_ff;
               else begin
                  delay_ff[sl_slot] <= sl_dec;
                  if (sl_dec == 16'd0) begin
                     phase_ff[sl_slot] <= PH_READY;
                     woke_ff <= woke_ff + 1'b1;
                     if (rcnt_ff < CW'(MAX_TASKS)) begin
                        rlist_ff[rcnt_ff[SW-1:0]] <= sl_slot;
                        rcnt_ff <= rcnt_ff + 1'b1;
                     end
                  end else begin
                     slist_ff[keep_ff[SW-1:0]] <= sl_slot;
                     keep_ff <= keep_ff + 1'b1;
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            EX_RESCHED: begin
               if (rcnt_ff == '0) begin
                  run_v_ff <= 1'b0;
                  run_ff   <= '0;
               end else begin
                  for (int i = 0; i < MAX_TASKS - 1; i++) begin
                     if (CW'(i + 1) < rcnt_ff) rlist_ff[i] <= rlist_ff[i + 1];
                  end
                  rlist_ff[SW'(rcnt_ff - 1'b1)] <= rlist_ff[0];
                  run_ff   <= rlist_ff[0];
                  run_v_ff <= 1'b1;
               end
            end
            EX_DONE: begin
               if (out_free) begin
                  out_ff.status        <= status_ff;
                  out_ff.current_valid <= run_v_ff;
                  out_ff.current_task  <= run_v_ff ? 3'(run_ff) : 3'd0;
                  out_ff.created_task  <= created_ff;
                  out_ff.woken_count   <= 4'(woke_ff);
                  out_ff.seconds_now   <= sec_ff;
                  out_ff.millis_now    <= ms_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   `RRTS_ASSERT(a_rcnt_bound, clock, reset, rcnt_ff <= CW'(MAX_TASKS), "ready list overflow")
   `RRTS_ASSERT(a_alloc_bound, clock, reset, alloc_ff <= CW'(MAX_TASKS), "slot table overflow")
   `RRTS_ASSERT(a_pop_idle, clock, reset, cmd_pop |=> st_ff == EX_DIV, "pop outside idle")
   `RRTS_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_data), "result lost")
endmodule

[sv/round_robin_task_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// round robin task scheduler unit
// task-state manager: slot table, ready/sleep lists, tick time counters
// ----------------------------------------------------------------------------
// sleep, tick and set seconds pass through the serial divider first; list walks take one entry a cycle
// the back end holds one command in flight at a time; a two-entry queue takes beats meanwhile
// reset: synchronous, clears lists, counters and slot table, countdown 1000
`timescale 1ns / 1ps
module round_robin_task_scheduler_unit
   import rrts_pkg::*;
#(
   parameter int MAX_TASKS = MaxTasksDefault
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [7:0] tick_rate_ff, tick_rate_in;
   logic       wr_en;
   hs_type     cmd_hs;
   logic       cmd_pop;
   cmd_type    cmd_data;

   // register write at the access phase; only address zero holds a register
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 1'b0) ? {24'd0, tick_rate_ff} : 32'd0;
   assign tick_rate_in = (wr_en && csr_paddr == 1'b0) ? csr_pwdata[7:0] : tick_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) tick_rate_ff <= 8'd1;
      else       tick_rate_ff <= tick_rate_in;
   end

   // front: takes beats and classifies
   rrts_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .cmd_hs   (cmd_hs),
      .cmd_pop  (cmd_pop),
      .cmd_data (cmd_data)
   );

   // back: executes one command at a time; the countdown keeps its value on a rate write
   rrts_back #(.MAX_TASKS(MAX_TASKS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_hs     (cmd_hs),
      .cmd_pop    (cmd_pop),
      .cmd_data   (cmd_data),
      .tick_rate  (tick_rate_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );
endmodule

[bench/rrts_checker.sv]
// ----------------------------------------------------------------------------
// rrts result checker
// watches request and result beats, predicts each result and compares fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rrts_checker
   import rrts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   input  logic    cfg_we,
   input  logic [7:0] cfg_value,
   output int      fail_count,
   output int      pending_count
);
   localparam int NSLOT = 8;

   rsp_type    result_queue[$];
   logic [7:0] tick_ms;
   phase_type  phase[NSLOT];
   logic [15:0] delay[NSLOT];
   int         ready_list[$];
   int         sleep_list[$];
   logic       run_valid;
   int         run_slot;
   int         alloc_n;
   logic [9:0] countdown;
   logic [31:0] secs;
   logic [31:0] msecs;

   assign pending_count = result_queue.size();

   function automatic int divisor();
      return (tick_ms == 0) ? 1 : int'(tick_ms);
   endfunction

   function automatic void drop(ref int lst[$], input int slot);
      for (int i = lst.size() - 1; i >= 0; i--)
         if (lst[i] == slot) lst.delete(i);
   endfunction

   function automatic void rotate();
      int head;
      if (ready_list.size() == 0) begin
         run_valid = 1'b0;
         run_slot = 0;
         return;
      end
      head = ready_list.pop_front();
      ready_list.push_back(head);
      run_slot = head;
      run_valid = 1'b1;
   endfunction

   function automatic void to_ready(int slot);
      drop(ready_list, slot);
      drop(sleep_list, slot);
      ready_list.push_back(slot);
      phase[slot] = PH_READY;
   endfunction

   function automatic rsp_type schedule_step(req_type r);
      rsp_type o;
      int slot;
      int keep[$];
      int woke;
      o = '0;
      woke = 0;
      case (mode_type'(r.mode))
         MODE_CREATE: begin
            if (alloc_n >= NSLOT) o.status = ST_FULL;
            else begin
               slot = alloc_n;
               alloc_n++;
               delay[slot] = 0;
               to_ready(slot);
               o.created_task = slot[2:0];
            end
         end
         MODE_TICK: begin
            countdown = countdown - 10'd1;
            if (countdown == 0) begin
               secs++;
               countdown = 10'(1000 / divisor());
            end
            msecs += tick_ms;
            foreach (sleep_list[i]) begin
               slot = sleep_list[i];
               if (delay[slot] != 0) delay[slot]--;
               if (delay[slot] == 0) begin
                  ready_list.push_back(slot);
                  phase[slot] = PH_READY;
                  woke++;
               end else keep.push_back(slot);
            end
            sleep_list = keep;
            rotate();
         end
         MODE_YIELD: rotate();
         MODE_SLEEP, MODE_SUSPEND: begin
            if (!run_valid) o.status = ST_NO_TASK;
            else begin
               slot = run_slot;
               drop(ready_list, slot);
               drop(sleep_list, slot);
               if (r.mode == MODE_SLEEP) begin
                  delay[slot] = 16'(int'(r.sleep_ms) / divisor());
                  sleep_list.push_back(slot);
                  phase[slot] = PH_SLEEP;
               end else phase[slot] = PH_SUSP;
               rotate();
            end
         end
         MODE_WAKEUP: begin
            if (int'(r.task_id) >= alloc_n) o.status = ST_NOT_ALLOC;
            else to_ready(int'(r.task_id));
         end
         MODE_SET_SEC: begin
            secs = r.time_value;
            countdown = 10'(1000 / divisor());
         end
         default: msecs = r.time_value;
      endcase
      o.current_valid = run_valid;
      o.current_task  = run_valid ? run_slot[2:0] : 3'd0;
      o.woken_count   = woke[3:0];
      o.seconds_now   = secs;
      o.millis_now    = msecs;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         tick_ms = 8'd1;
         foreach (phase[i]) begin
            phase[i] = PH_FREE;
            delay[i] = 0;
         end
         ready_list.delete();
         sleep_list.delete();
         run_valid = 0;
         run_slot = 0;
         alloc_n = 0;
         countdown = 10'd1000;
         secs = 0;
         msecs = 0;
         result_queue.delete();
         fail_count = 0;
      end else begin
         if (cfg_we) tick_ms = cfg_value;
         if (rsp_valid && !rsp_stall) begin
            if (result_queue.size() == 0) begin
               $error("result beat with nothing expected");
               fail_count++;
            end else begin
               e = result_queue.pop_front();
               if (rsp_data.status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.current_valid !== e.current_valid) begin
                  $error("current_valid exp %0d got %0d", e.current_valid,
                         rsp_data.current_valid);
                  fail_count++;
               end
               if (rsp_data.current_task !== e.current_task) begin
                  $error("current_task exp %0d got %0d", e.current_task,
                         rsp_data.current_task);
                  fail_count++;
               end
               if (rsp_data.created_task !== e.created_task) begin
                  $error("created_task exp %0d got %0d", e.created_task,
                         rsp_data.created_task);
                  fail_count++;
               end
               if (rsp_data.woken_count !== e.woken_count) begin
                  $error("woken_count exp %0d got %0d", e.woken_count,
                         rsp_data.woken_count);
                  fail_count++;
               end
               if (rsp_data.seconds_now !== e.seconds_now) begin
                  $error("seconds_now exp %0d got %0d", e.seconds_now,
                         rsp_data.seconds_now);
                  fail_count++;
               end
               if (rsp_data.millis_now !== e.millis_now) begin
                  $error("millis_now exp %0d got %0d", e.millis_now,
                         rsp_data.millis_now);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) result_queue.push_back(schedule_step(req_data));
      end
   end
endmodule

[bench/tb_round_robin_task_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// task scheduler testbench
// drives commands and register writes, checker predicts and compares results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_round_robin_task_scheduler_unit;
   import rrts_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic        csr_paddr = 1'b0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   logic        calm = 1'b0;   // no idling in the last part
   int          beat_count = 0;
   logic [7:0]  rates [6] = '{8'd250, 8'd0, 8'd7, 8'd1, 8'd100, 8'd3};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   round_robin_task_scheduler_unit uut (.*);

   // a register write lands at the edge with psel, penable and pwrite high
   rrts_checker checker_inst (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .cfg_we(csr_psel && csr_penable && csr_pwrite && csr_pready),
      .cfg_value(csr_pwdata[7:0]),
      .fail_count, .pending_count
   );

   // watchdog, far above slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("round_robin_task_scheduler_unit: mismatch");
         $finish;
      end
   end

   // result side stalls in random bursts
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 4);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // register write during idle
   task automatic write_rate(input logic [7:0] v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 1'b0;
      csr_pwdata <= {24'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // wait until every result is back, then let the block settle
   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // one command beat, with an optional random gap ahead of it
   task automatic send(input mode_type m, input logic [2:0] id,
                       input logic [15:0] ms, input logic [31:0] tv);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{mode: m, task_id: id, sleep_ms: ms, time_value: tv};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beat_count++;
   endtask

   task automatic idle_req();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // mostly well-formed: tick heavy, with wakeup, sleep, yield and create; few set/noise
   task automatic random_beat();
      int p;
      p = $urandom_range(0, 99);
      if (p < 8) send(MODE_CREATE, 3'($urandom), 16'($urandom), $urandom);
      else if (p < 45) send(MODE_TICK, 3'($urandom), 16'($urandom), $urandom);
      else if (p < 55) send(MODE_YIELD, 3'($urandom), 16'($urandom), $urandom);
      else if (p < 70)
         send(MODE_SLEEP, 3'($urandom),
              ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
              $urandom);
      else if (p < 76) send(MODE_SUSPEND, 3'($urandom), 16'($urandom), $urandom);
      else if (p < 92) send(MODE_WAKEUP, 3'($urandom), 16'($urandom), $urandom);
      else if (p < 96) send(MODE_SET_SEC, 3'($urandom), 16'($urandom), $urandom);
      else send(MODE_SET_MS, 3'($urandom), 16'($urandom), $urandom);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle errors, allocation, full table, wakeups, extremes
      send(MODE_SLEEP, 3'd0, 16'd5, 32'd0);        // sleep while idle
      send(MODE_SUSPEND, 3'd0, 16'd0, 32'd0);      // suspend while idle
      send(MODE_YIELD, 3'd0, 16'd0, 32'd0);        // yield with empty list
      send(MODE_WAKEUP, 3'd7, 16'd0, 32'd0);       // unallocated slot
      send(MODE_TICK, 3'd0, 16'd0, 32'd0);
      for (int i = 0; i < 9; i++) send(MODE_CREATE, 3'd0, 16'd0, 32'd0);
      send(MODE_YIELD, 3'd0, 16'd0, 32'd0);
      send(MODE_WAKEUP, 3'd3, 16'd0, 32'd0);       // wake a ready task
      send(MODE_SLEEP, 3'd0, 16'hFFFF, 32'hFFFF_FFFF);
      send(MODE_SLEEP, 3'd0, 16'd0, 32'd0);        // zero delay
      send(MODE_SUSPEND, 3'd0, 16'd0, 32'd0);
      send(MODE_TICK, 3'd0, 16'd0, 32'd0);
      send(MODE_SET_SEC, 3'd0, 16'd0, 32'hFFFF_FFFF);
      send(MODE_SET_MS, 3'd0, 16'd0, 32'hFFFF_FFFE);
      send(MODE_TICK, 3'd0, 16'd0, 32'd0);         // counters near their top values
      send(MODE_WAKEUP, 3'd1, 16'd0, 32'd0);       // wake a task that a tick has made ready
      idle_req();
      drain();

      // random phases across tick rates, extremes included; zero is odd case
      foreach (rates[k]) begin
         write_rate(rates[k]);
         if (k == 5) calm = 1'b1;
         for (int i = 0; i < 71; i++) random_beat();
         idle_req();
         drain();
      end

      $display("ran %0d command beats over six tick rates, sleep and wakeup mixes",
               beat_count);
      if (fail_count == 0) $display("round_robin_task_scheduler_unit: match");
      else $display("round_robin_task_scheduler_unit: mismatch");
      $finish;
   end
endmodule

[files.f]
+incdir+sv
sv/rrts_pkg.sv
sv/rrts_front.sv
sv/rrts_back.sv
sv/round_robin_task_scheduler_unit.sv
bench/rrts_checker.sv
bench/tb_round_robin_task_scheduler_unit.sv
